// ===== design/hrbp_pkg.sv =====
package hrbp_pkg;

	localparam int LENGTH_BITS_DEF = 32;
	localparam logic [15:0] MAX_PATH_RST = 16'd8192;
	localparam int PATH_BITS = 17;
	localparam logic [PATH_BITS-1:0] PATH_COUNT_MAX = '1;
	localparam logic [3:0] KEY_LEN = 4'd14;

	typedef enum logic [13:0] {
		PH_START     = 14'h0001,
		PH_METHOD    = 14'h0002,
		PH_PATH      = 14'h0004,
		PH_QKEY      = 14'h0008,
		PH_QVAL      = 14'h0010,
		PH_FRAG      = 14'h0020,
		PH_VERSION   = 14'h0040,
		PH_LF_STATUS = 14'h0080,
		PH_HKEY      = 14'h0100,
		PH_HVAL      = 14'h0200,
		PH_LF_HDR    = 14'h0400,
		PH_LF_END    = 14'h0800,
		PH_BODY      = 14'h1000,
		PH_DONE      = 14'h2000
	} phase_t;

	localparam logic [3:0] ROLE_NONE    = 4'd0;
	localparam logic [3:0] ROLE_METHOD  = 4'd1;
	localparam logic [3:0] ROLE_PATH    = 4'd2;
	localparam logic [3:0] ROLE_QKEY    = 4'd3;
	localparam logic [3:0] ROLE_QVAL    = 4'd4;
	localparam logic [3:0] ROLE_VERSION = 4'd5;
	localparam logic [3:0] ROLE_HKEY    = 4'd6;
	localparam logic [3:0] ROLE_HVAL    = 4'd7;
	localparam logic [3:0] ROLE_BODY    = 4'd8;

	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_PAIR_END  = 3'd1;
	localparam logic [2:0] EV_HDR_END   = 3'd2;
	localparam logic [2:0] EV_HDRS_DONE = 3'd3;
	localparam logic [2:0] EV_COMPLETE  = 3'd4;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUERY = 8'h3f;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_COLON = 8'h3a;

	// "content-length", one character per position
	function automatic logic [7:0] cl_key_byte(input logic [3:0] pos);
		logic [7:0] b;
		unique case (pos)
			4'd0:    b = 8'h63;
			4'd1:    b = 8'h6f;
			4'd2:    b = 8'h6e;
			4'd3:    b = 8'h74;
			4'd4:    b = 8'h65;
			4'd5:    b = 8'h6e;
			4'd6:    b = 8'h74;
			4'd7:    b = 8'h2d;
			4'd8:    b = 8'h6c;
			4'd9:    b = 8'h65;
			4'd10:   b = 8'h6e;
			4'd11:   b = 8'h67;
			4'd12:   b = 8'h74;
			4'd13:   b = 8'h68;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== design/http_request_byte_parser.sv =====
// HTTP request byte parser. Takes one request byte per word on s_* and returns one tagged
// word per byte on m_*: the byte's role (method, path, query key/value, version, lowercased
// header key, header value, body), the byte itself, an event code and an error flag. A
// rejected byte leaves the parse state untouched. One byte is accepted every cycle while the
// output is free or being taken; each result appears in the cycle after its byte, held in a
// single output register, refilled in the same cycle it is taken. The content-length value
// is gathered by a saturating multiply-by-ten accumulator of LENGTH_BITS bits, which is the
// widest path. max_path_length is written on cfg_* and should only change between requests.
module http_request_byte_parser #(
	parameter int LENGTH_BITS = hrbp_pkg::LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] event_res, [11] error, rest zero
	output logic [3:0]  m_tuser,   // [3:0] role
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // [15:0] max_path_length
);

	localparam int PB = hrbp_pkg::PATH_BITS;

	hrbp_pkg::phase_t phase_q, phase_nxt;
	logic [15:0]            max_path_q;
	logic [PB-1:0]          path_count_q, path_count_nxt;
	logic                   value_empty_q, value_empty_nxt;
	logic [3:0]             key_pos_q, key_pos_nxt;
	logic                   key_match_q, key_match_nxt;
	logic                   digits_open_q, digits_open_nxt;
	logic [LENGTH_BITS-1:0] accum_q, accum_nxt;
	logic [LENGTH_BITS-1:0] content_len_q, content_len_nxt;
	logic [LENGTH_BITS-1:0] body_left_q, body_left_nxt;

	logic                   m_tvalid_q;
	logic [3:0]             role_q;
	logic [7:0]             out_byte_q;
	logic [2:0]             event_q;
	logic                   error_q;

	logic [7:0]             c, lc;
	logic                   is_alpha, is_digit, cl_hdr, accept;
	logic [3:0]             role;
	logic [7:0]             ob;
	logic [2:0]             ev;
	logic                   err;
	logic [LENGTH_BITS+3:0] acc_ext, acc_mul;
	logic [LENGTH_BITS-1:0] acc_sat, body_dec;

	assign c        = s_tdata;
	assign lc       = (c >= 8'h41 && c <= 8'h5a) ? (c | 8'h20) : c;
	assign is_alpha = (lc >= 8'h61 && lc <= 8'h7a);
	assign is_digit = (c >= 8'h30 && c <= 8'h39);
	assign cl_hdr   = key_match_q && (key_pos_q == hrbp_pkg::KEY_LEN);

	// times ten plus digit; carry out of the low LENGTH_BITS means saturate
	assign acc_ext = {4'd0, accum_q};
	assign acc_mul = (acc_ext << 3) + (acc_ext << 1) + {{LENGTH_BITS{1'b0}}, c[3:0]};
	assign acc_sat = (|acc_mul[LENGTH_BITS+3:LENGTH_BITS]) ? '1 : acc_mul[LENGTH_BITS-1:0];

	assign body_dec = body_left_q - {{(LENGTH_BITS-1){1'b0}}, (body_left_q != '0)};

	assign s_tready  = !m_tvalid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_comb begin
		phase_nxt       = phase_q;
		path_count_nxt  = path_count_q;
		value_empty_nxt = value_empty_q;
		key_pos_nxt     = key_pos_q;
		key_match_nxt   = key_match_q;
		digits_open_nxt = digits_open_q;
		accum_nxt       = accum_q;
		content_len_nxt = content_len_q;
		body_left_nxt   = body_left_q;
		role            = hrbp_pkg::ROLE_NONE;
		ob              = c;
		ev              = hrbp_pkg::EV_NONE;
		err             = 1'b0;
		unique case (phase_q)
			hrbp_pkg::PH_START: begin
				if (is_alpha) begin
					role      = hrbp_pkg::ROLE_METHOD;
					phase_nxt = hrbp_pkg::PH_METHOD;
				end else if (c != hrbp_pkg::CH_CR && c != hrbp_pkg::CH_LF) begin
					err = 1'b1;
				end
			end
			hrbp_pkg::PH_METHOD: begin
				if (c == hrbp_pkg::CH_SPACE) phase_nxt = hrbp_pkg::PH_PATH;
				else role = hrbp_pkg::ROLE_METHOD;
			end
			hrbp_pkg::PH_PATH: begin
				if (path_count_q > {1'b0, max_path_q}) begin
					err = 1'b1;
				end else if (c == hrbp_pkg::CH_QUERY) begin
					phase_nxt = hrbp_pkg::PH_QKEY;
				end else if (c == hrbp_pkg::CH_HASH) begin
					phase_nxt = hrbp_pkg::PH_FRAG;
				end else if (c == hrbp_pkg::CH_SPACE) begin
					phase_nxt = hrbp_pkg::PH_VERSION;
				end else begin
					role = hrbp_pkg::ROLE_PATH;
					if (path_count_q != hrbp_pkg::PATH_COUNT_MAX)
						path_count_nxt = path_count_q + {{(PB-1){1'b0}}, 1'b1};
				end
			end
			hrbp_pkg::PH_QKEY: begin
				if (c == hrbp_pkg::CH_EQ) phase_nxt = hrbp_pkg::PH_QVAL;
				else if (c == hrbp_pkg::CH_SPACE) phase_nxt = hrbp_pkg::PH_VERSION;
				else role = hrbp_pkg::ROLE_QKEY;
			end
			hrbp_pkg::PH_QVAL: begin
				if (c == hrbp_pkg::CH_AMP) begin
					ev        = hrbp_pkg::EV_PAIR_END;
					phase_nxt = hrbp_pkg::PH_QKEY;
				end else if (c == hrbp_pkg::CH_HASH) begin
					ev        = hrbp_pkg::EV_PAIR_END;
					phase_nxt = hrbp_pkg::PH_FRAG;
				end else if (c == hrbp_pkg::CH_SPACE) begin
					ev        = hrbp_pkg::EV_PAIR_END;
					phase_nxt = hrbp_pkg::PH_VERSION;
				end else begin
					role = hrbp_pkg::ROLE_QVAL;
				end
			end
			hrbp_pkg::PH_FRAG: begin
				if (c == hrbp_pkg::CH_SPACE) phase_nxt = hrbp_pkg::PH_VERSION;
			end
			hrbp_pkg::PH_VERSION: begin
				if (c == hrbp_pkg::CH_CR) phase_nxt = hrbp_pkg::PH_LF_STATUS;
				else role = hrbp_pkg::ROLE_VERSION;
			end
			hrbp_pkg::PH_LF_STATUS, hrbp_pkg::PH_LF_HDR: begin
				if (c == hrbp_pkg::CH_LF) begin
					phase_nxt     = hrbp_pkg::PH_HKEY;
					key_pos_nxt   = 4'd0;
					key_match_nxt = 1'b1;
				end else begin
					err = 1'b1;
				end
			end
			hrbp_pkg::PH_HKEY: begin
				if (c == hrbp_pkg::CH_COLON) begin
					phase_nxt       = hrbp_pkg::PH_HVAL;
					value_empty_nxt = 1'b1;
					digits_open_nxt = 1'b1;
					accum_nxt       = '0;
				end else if (c == hrbp_pkg::CH_CR) begin
					// blank line, or a key with no colon: both end the header section
					phase_nxt     = hrbp_pkg::PH_LF_END;
					key_pos_nxt   = 4'd0;
					key_match_nxt = 1'b1;
				end else begin
					role = hrbp_pkg::ROLE_HKEY;
					ob   = lc;
					if (key_match_q && key_pos_q < hrbp_pkg::KEY_LEN &&
					    lc == hrbp_pkg::cl_key_byte(key_pos_q))
						key_pos_nxt = key_pos_q + 4'd1;
					else
						key_match_nxt = 1'b0;
				end
			end
			hrbp_pkg::PH_HVAL: begin
				if (c == hrbp_pkg::CH_SPACE && value_empty_q) begin
					// leading space skipped
				end else if (c == hrbp_pkg::CH_CR) begin
					ev = hrbp_pkg::EV_HDR_END;
					if (cl_hdr) content_len_nxt = accum_q;
					key_pos_nxt     = 4'd0;
					key_match_nxt   = 1'b1;
					value_empty_nxt = 1'b1;
					phase_nxt       = hrbp_pkg::PH_LF_HDR;
				end else begin
					role            = hrbp_pkg::ROLE_HVAL;
					value_empty_nxt = 1'b0;
					if (cl_hdr && digits_open_q) begin
						if (is_digit) accum_nxt = acc_sat;
						else digits_open_nxt = 1'b0;
					end
				end
			end
			hrbp_pkg::PH_LF_END: begin
				if (c == hrbp_pkg::CH_LF) begin
					body_left_nxt = content_len_q;
					if (content_len_q != '0) begin
						ev        = hrbp_pkg::EV_HDRS_DONE;
						phase_nxt = hrbp_pkg::PH_BODY;
					end else begin
						ev        = hrbp_pkg::EV_COMPLETE;
						phase_nxt = hrbp_pkg::PH_DONE;
					end
				end else begin
					err = 1'b1;
				end
			end
			hrbp_pkg::PH_BODY: begin
				role          = hrbp_pkg::ROLE_BODY;
				body_left_nxt = body_dec;
				if (body_dec == '0) begin
					ev        = hrbp_pkg::EV_COMPLETE;
					phase_nxt = hrbp_pkg::PH_DONE;
				end
			end
			default: err = 1'b1;
		endcase
		if (err) begin
			role = hrbp_pkg::ROLE_NONE;
			ev   = hrbp_pkg::EV_NONE;
			ob   = c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= hrbp_pkg::PH_START;
			max_path_q    <= hrbp_pkg::MAX_PATH_RST;
			path_count_q  <= '0;
			value_empty_q <= 1'b1;
			key_pos_q     <= 4'd0;
			key_match_q   <= 1'b1;
			digits_open_q <= 1'b1;
			accum_q       <= '0;
			content_len_q <= '0;
			body_left_q   <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				max_path_q <= cfg_data;
			if (accept) begin
				phase_q       <= phase_nxt;
				path_count_q  <= path_count_nxt;
				value_empty_q <= value_empty_nxt;
				key_pos_q     <= key_pos_nxt;
				key_match_q   <= key_match_nxt;
				digits_open_q <= digits_open_nxt;
				accum_q       <= accum_nxt;
				content_len_q <= content_len_nxt;
				body_left_q   <= body_left_nxt;
			end
			if (accept)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			role_q     <= role;
			out_byte_q <= ob;
			event_q    <= ev;
			error_q    <= err;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = role_q;
	assign m_tdata  = {4'd0, error_q, event_q, out_byte_q};

`ifndef SYNTHESIS
	// a rejected byte carries no role and no event
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && error_q |-> role_q == hrbp_pkg::ROLE_NONE &&
			event_q == hrbp_pkg::EV_NONE)
		else $error("error word with role or event set");

	// body countdown is live only in the body phase
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == hrbp_pkg::PH_BODY) == (body_left_q != '0))
		else $error("body count out of step with phase");

	// path counter moves only while in the path phase
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != hrbp_pkg::PH_PATH |=> $stable(path_count_q))
		else $error("path count changed outside path phase");
`endif

endmodule
